### rtl/core/tlc_pkg.sv
// ----------------------------------------------------------------------------
// tlc_pkg
// shared types and constants of the target tilt and lane counter
// ----------------------------------------------------------------------------
package tlc_pkg;

  localparam int unsigned LANES_DEF   = 8;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned CFG_DATA_W  = 24;

  localparam logic KIND_TARGET = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef enum logic [2:0] {
    CFG_COS_EL,
    CFG_SIN_EL,
    CFG_HEIGHT,
    CFG_LANE_COUNT,
    CFG_LANE_LEFT,
    CFG_LANE_NEAR,
    CFG_LANE_WIDTH,
    CFG_LANE_DEPTH
  } cfg_idx_e;

  typedef enum logic {
    BK_ITEM,
    BK_REPORT
  } bk_state_e;

  typedef struct packed {
    logic signed [15:0] cos_el;
    logic signed [15:0] sin_el;
    logic signed [23:0] height_offset;
    logic        [3:0]  lane_count;
    logic signed [23:0] lane_left;
    logic signed [23:0] lane_near;
    logic        [22:0] lane_width;
    logic        [22:0] lane_depth;
  } cfg_t;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic        [7:0]  target_id;
    logic               has_target;
    logic               frame_end;
  } in_beat_t;

  typedef struct packed {
    logic               kind;
    logic signed [23:0] out_x;
    logic signed [23:0] out_y;
    logic signed [23:0] out_z;
    logic        [7:0]  out_id;
    logic               lane_hit;
    logic        [2:0]  lane_index;
    logic        [15:0] lane_total;
    logic               last;
  } out_beat_t;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic        [7:0]  id;
    logic               has_target;
    logic               frame_end;
    logic               hit;
  } fe_entry_t;

endpackage

### rtl/core/tlc_front.sv
// ----------------------------------------------------------------------------
// tlc_front
// two-stage front end: tilt products, then floor, height add, saturation and
// the lane x and y tests; hands classified beats to the queue
// ----------------------------------------------------------------------------
module tlc_front #(
  parameter int unsigned LANES = tlc_pkg::LANES_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  tlc_pkg::cfg_t                           cfg_i,
  input  logic [$clog2(LANES+1)-1:0]              used_i,
  input  logic                                    push_i,
  output logic                                    full_o,
  input  tlc_pkg::in_beat_t                       in_i,
  input  logic                                    q_full_i,
  output logic                                    q_push_o,
  output tlc_pkg::fe_entry_t                      q_entry_o,
  output logic [((LANES > 1) ? $clog2(LANES) : 1)-1:0] q_idx_o
);

  localparam int unsigned IDX_W = $clog2(LANES + 1);
  localparam int unsigned LI_W  = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int unsigned BND_W = 25 + IDX_W;

  logic signed [BND_W-1:0] bound_d [LANES+1];
  logic signed [BND_W-1:0] bound_q [LANES+1];
  logic signed [24:0]      ytop_d, ytop_q;
  logic        [BND_W-1:0] wid_ext;

  logic signed [15:0] c_el, s_el;
  logic signed [23:0] py, pz;
  logic signed [39:0] cy_d, sz_d, sy_d, cz_d;
  logic signed [39:0] cy_q, sz_q, sy_q, cz_q;
  logic signed [BND_W-1:0] x_ext;
  logic [LANES-1:0]   xin;

  logic               adv;
  logic               s1_v_q, s2_v_q;
  logic signed [23:0] s1_x_q;
  logic        [7:0]  s1_id_q;
  logic               s1_ht_q, s1_fe_q;

  logic signed [40:0] sum_y, sum_z;
  logic signed [27:0] fy, zt;
  logic signed [23:0] ny, nz;
  logic               yin;
  logic [LANES-1:0]   hv;
  logic [LI_W-1:0]    hidx;

  tlc_pkg::fe_entry_t s2_d, s2_q;
  logic [LI_W-1:0]    s2_idx_q;
  logic               s2_need;

  function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
    logic signed [23:0] r;
    if (v > 28'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -28'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  // lane edges follow the registers
  assign wid_ext = BND_W'(cfg_i.lane_width);

  always_comb begin
    for (int l = 0; l <= LANES; l++) begin
      bound_d[l] = BND_W'(cfg_i.lane_left) + $signed(wid_ext * BND_W'(l));
    end
    ytop_d = 25'(cfg_i.lane_near) + $signed({2'b00, cfg_i.lane_depth});
  end

  always_ff @(posedge clk_i) begin
    bound_q <= bound_d;
    ytop_q  <= ytop_d;
  end

  // stage 1
  assign c_el = cfg_i.cos_el;
  assign s_el = cfg_i.sin_el;
  assign py   = in_i.pos_y;
  assign pz   = in_i.pos_z;
  assign cy_d = c_el * py;
  assign sz_d = s_el * pz;
  assign sy_d = s_el * py;
  assign cz_d = c_el * pz;

  assign s2_need  = s2_q.has_target | s2_q.frame_end;
  assign adv      = !(s2_v_q && s2_need && q_full_i);
  assign full_o   = !adv;
  assign q_push_o = s2_v_q && s2_need && !q_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= push_i;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cy_q    <= cy_d;
      sz_q    <= sz_d;
      sy_q    <= sy_d;
      cz_q    <= cz_d;
      s1_x_q  <= in_i.pos_x;
      s1_id_q <= in_i.target_id;
      s1_ht_q <= in_i.has_target;
      s1_fe_q <= in_i.frame_end;
    end
  end

  // stage 2
  assign x_ext = BND_W'(s1_x_q);

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      xin[l] = (x_ext >= bound_q[l]) && (x_ext < bound_q[l+1]) && (l < int'(used_i));
    end
  end

  assign sum_y = 41'(cy_q) - 41'(sz_q);
  assign sum_z = 41'(sy_q) + 41'(cz_q);
  assign fy    = 28'($signed(sum_y[40:14]));
  assign zt    = 28'($signed(sum_z[40:14])) + 28'(cfg_i.height_offset);
  assign ny    = sat24(fy);
  assign nz    = sat24(zt);
  assign yin   = (25'(ny) >= 25'(cfg_i.lane_near)) && (25'(ny) < ytop_q);
  assign hv    = xin & {LANES{yin}};

  always_comb begin
    hidx = '0;
    for (int l = LANES - 1; l >= 0; l--) begin
      if (hv[l]) begin
        hidx = LI_W'(l);
      end
    end
  end

  always_comb begin
    s2_d            = '0;
    s2_d.x          = s1_x_q;
    s2_d.y          = ny;
    s2_d.z          = nz;
    s2_d.id         = s1_id_q;
    s2_d.has_target = s1_ht_q;
    s2_d.frame_end  = s1_fe_q;
    s2_d.hit        = |hv;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_q     <= s2_d;
      s2_idx_q <= hidx;
    end
  end

  assign q_entry_o = s2_q;
  assign q_idx_o   = s2_idx_q;

endmodule

### rtl/core/tlc_queue.sv
// ----------------------------------------------------------------------------
// tlc_queue
// short queue between front and back end
// ----------------------------------------------------------------------------
module tlc_queue #(
  parameter int unsigned DEPTH  = tlc_pkg::QUEUE_DEPTH,
  parameter int unsigned DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic [DATA_W-1:0] rdata_o,
  output logic              empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

### rtl/core/tlc_back.sv
// ----------------------------------------------------------------------------
// tlc_back
// back end: lane counts, target results, frame-end count reports and the
// result register
// ----------------------------------------------------------------------------
module tlc_back #(
  parameter int unsigned LANES = tlc_pkg::LANES_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic [$clog2(LANES+1)-1:0]              used_i,
  input  tlc_pkg::fe_entry_t                      head_i,
  input  logic [((LANES > 1) ? $clog2(LANES) : 1)-1:0] head_idx_i,
  input  logic                                    q_empty_i,
  output logic                                    q_pop_o,
  output logic                                    empty_o,
  input  logic                                    pop_i,
  output tlc_pkg::out_beat_t                      out_o
);

  localparam int unsigned IDX_W = $clog2(LANES + 1);
  localparam int unsigned LI_W  = (LANES > 1) ? $clog2(LANES) : 1;

  tlc_pkg::bk_state_e state_q, state_d;
  logic [15:0]        cnt_q [LANES];
  logic [LI_W-1:0]    rpt_q, rpt_d;
  logic [LI_W-1:0]    rd_idx;
  logic [15:0]        cnt_rd, cnt_inc;
  logic               ld_ok, last_rpt, rpt_go;
  logic               out_load, inc_en, clr;
  logic               out_v_q;
  tlc_pkg::out_beat_t out_d, out_q;

  assign ld_ok    = !out_v_q || pop_i;
  assign rd_idx   = (state_q == tlc_pkg::BK_REPORT) ? rpt_q : head_idx_i;
  assign cnt_rd   = cnt_q[rd_idx];
  assign cnt_inc  = (cnt_rd == 16'hFFFF) ? cnt_rd : cnt_rd + 16'd1;
  assign last_rpt = (IDX_W'(rpt_q) + IDX_W'(1)) == used_i;
  assign rpt_go   = head_i.frame_end && (used_i != '0);

  always_comb begin
    state_d = state_q;
    case (state_q)
      tlc_pkg::BK_ITEM: begin
        if (!q_empty_i && ld_ok && rpt_go) begin
          state_d = tlc_pkg::BK_REPORT;
        end
      end
      tlc_pkg::BK_REPORT: begin
        if (ld_ok && last_rpt) begin
          state_d = tlc_pkg::BK_ITEM;
        end
      end
      default: state_d = tlc_pkg::BK_ITEM;
    endcase
  end

  always_comb begin
    q_pop_o  = 1'b0;
    out_load = 1'b0;
    inc_en   = 1'b0;
    clr      = 1'b0;
    rpt_d    = rpt_q;
    out_d    = '0;
    case (state_q)
      tlc_pkg::BK_ITEM: begin
        if (!q_empty_i && ld_ok) begin
          q_pop_o = 1'b1;
          rpt_d   = '0;
          if (head_i.has_target) begin
            out_load     = 1'b1;
            inc_en       = head_i.hit;
            out_d.kind   = tlc_pkg::KIND_TARGET;
            out_d.out_x  = head_i.x;
            out_d.out_y  = head_i.y;
            out_d.out_z  = head_i.z;
            out_d.out_id = head_i.id;
            out_d.last   = !rpt_go;
            if (head_i.hit) begin
              out_d.lane_hit   = 1'b1;
              out_d.lane_index = 3'(head_idx_i);
              out_d.lane_total = cnt_inc;
            end
          end
          if (head_i.frame_end && !rpt_go) begin
            clr = 1'b1;
          end
        end
      end
      tlc_pkg::BK_REPORT: begin
        if (ld_ok) begin
          out_load         = 1'b1;
          out_d.kind       = tlc_pkg::KIND_REPORT;
          out_d.lane_index = 3'(rpt_q);
          out_d.lane_total = cnt_rd;
          out_d.last       = last_rpt;
          rpt_d            = rpt_q + LI_W'(1);
          clr              = last_rpt;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tlc_pkg::BK_ITEM;
      rpt_q   <= '0;
      out_v_q <= 1'b0;
      for (int l = 0; l < LANES; l++) begin
        cnt_q[l] <= '0;
      end
    end else begin
      state_q <= state_d;
      rpt_q   <= rpt_d;
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (pop_i) begin
        out_v_q <= 1'b0;
      end
      if (clr) begin
        for (int l = 0; l < LANES; l++) begin
          cnt_q[l] <= '0;
        end
      end else if (inc_en) begin
        cnt_q[head_idx_i] <= cnt_inc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign empty_o = !out_v_q;
  assign out_o   = out_q;

endmodule

### rtl/core/target_tilt_and_lane_counter_core.sv
// ----------------------------------------------------------------------------
// target_tilt_and_lane_counter_core
// tilts radar targets about x, adds mounting height, tests lane rectangles
// and reports per-lane counts at frame end
// ----------------------------------------------------------------------------
// throughput: one target per cycle through the front pipeline and back end, unless held by full queues, pop or reports
// a frame end sends one count report per enabled lane, after the target result
// if it carries one; the back end count sequencer steps through the lanes
// reset: the config registers return to their reset values, counts and queues are emptied
// ----------------------------------------------------------------------------
module target_tilt_and_lane_counter_core #(
  parameter int unsigned LANES = tlc_pkg::LANES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [2:0]                          cfg_idx_i,
  input  logic [tlc_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                push,
  output logic                                full,
  input  tlc_pkg::in_beat_t                   in_data_i,
  output logic                                empty,
  input  logic                                pop,
  output tlc_pkg::out_beat_t                  out_data_o
);

  localparam int unsigned IDX_W  = $clog2(LANES + 1);
  localparam int unsigned LI_W   = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int unsigned ENT_W  = $bits(tlc_pkg::fe_entry_t);
  localparam int unsigned DATA_W = LI_W + ENT_W;

  tlc_pkg::cfg_t      cfg_q;
  logic [IDX_W-1:0]   used;
  logic               q_push, q_full, q_pop, q_empty;
  tlc_pkg::fe_entry_t f_entry, b_entry;
  logic [LI_W-1:0]    f_idx, b_idx;
  logic [DATA_W-1:0]  q_wdata, q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= tlc_pkg::cfg_t'{cos_el: 16'sd16384, default: '0};
    end else if (cfg_we_i) begin
      case (tlc_pkg::cfg_idx_e'(cfg_idx_i))
        tlc_pkg::CFG_COS_EL:     cfg_q.cos_el        <= cfg_wdata_i[15:0];
        tlc_pkg::CFG_SIN_EL:     cfg_q.sin_el        <= cfg_wdata_i[15:0];
        tlc_pkg::CFG_HEIGHT:     cfg_q.height_offset <= cfg_wdata_i[23:0];
        tlc_pkg::CFG_LANE_COUNT: cfg_q.lane_count    <= cfg_wdata_i[3:0];
        tlc_pkg::CFG_LANE_LEFT:  cfg_q.lane_left     <= cfg_wdata_i[23:0];
        tlc_pkg::CFG_LANE_NEAR:  cfg_q.lane_near     <= cfg_wdata_i[23:0];
        tlc_pkg::CFG_LANE_WIDTH: cfg_q.lane_width    <= cfg_wdata_i[22:0];
        tlc_pkg::CFG_LANE_DEPTH: cfg_q.lane_depth    <= cfg_wdata_i[22:0];
        default: begin
        end
      endcase
    end
  end

  // lanes beyond the build size are ignored
  always_comb begin
    if (int'(cfg_q.lane_count) > LANES) begin
      used = IDX_W'(LANES);
    end else begin
      used = IDX_W'(cfg_q.lane_count);
    end
  end

  tlc_front #(
    .LANES (LANES)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .used_i    (used),
    .push_i    (push),
    .full_o    (full),
    .in_i      (in_data_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_entry_o (f_entry),
    .q_idx_o   (f_idx)
  );

  assign q_wdata = {f_idx, f_entry};

  tlc_queue #(
    .DEPTH  (tlc_pkg::QUEUE_DEPTH),
    .DATA_W (DATA_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  assign b_entry = q_rdata[ENT_W-1:0];
  assign b_idx   = q_rdata[DATA_W-1:ENT_W];

  tlc_back #(
    .LANES (LANES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .used_i     (used),
    .head_i     (b_entry),
    .head_idx_i (b_idx),
    .q_empty_i  (q_empty),
    .q_pop_o    (q_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_o      (out_data_o)
  );

endmodule

### dv/target_tilt_and_lane_counter_core_tb.sv
// ----------------------------------------------------------------------------
// target_tilt_and_lane_counter_core_tb
// drives radar targets, frame ends and register writes into the core, predicts
// the tilted targets and lane count reports, and checks every result beat in
// order under several idle, stall and back-pressure patterns
// ----------------------------------------------------------------------------
module target_tilt_and_lane_counter_core_tb;

  localparam int unsigned LANES     = tlc_pkg::LANES_DEF;
  localparam int unsigned RUN_LIMIT = 1000000;

  typedef enum logic {
    ROW_REG,
    ROW_BEAT
  } row_kind_e;

  typedef struct {
    row_kind_e          kind;
    tlc_pkg::cfg_idx_e  idx;
    int                 wdata;
    tlc_pkg::in_beat_t  beat;
    bit                 typed;
    tlc_pkg::out_beat_t want;
  } plan_row_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [2:0]                     cfg_idx_i;
  logic [tlc_pkg::CFG_DATA_W-1:0] cfg_wdata_i;
  logic                           push;
  logic                           full;
  tlc_pkg::in_beat_t              in_data_i;
  logic                           empty;
  logic                           pop;
  tlc_pkg::out_beat_t             out_data_o;

  tlc_pkg::cfg_t      tilt_cfg;
  logic [15:0]        lane_tally [LANES];
  tlc_pkg::out_beat_t awaited [$];
  plan_row_t          plan [$];
  int                 failures;
  int                 tx_idle_pct;
  int                 rx_stall_pct;
  bit                 hold_req;

  target_tilt_and_lane_counter_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data_i),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    rst_ni <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic longint clip24(input longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  task automatic apply_reg(input tlc_pkg::cfg_idx_e idx, input logic [23:0] v);
    case (idx)
      tlc_pkg::CFG_COS_EL:     tilt_cfg.cos_el = v[15:0];
      tlc_pkg::CFG_SIN_EL:     tilt_cfg.sin_el = v[15:0];
      tlc_pkg::CFG_HEIGHT:     tilt_cfg.height_offset = v;
      tlc_pkg::CFG_LANE_COUNT: tilt_cfg.lane_count = v[3:0];
      tlc_pkg::CFG_LANE_LEFT:  tilt_cfg.lane_left = v;
      tlc_pkg::CFG_LANE_NEAR:  tilt_cfg.lane_near = v;
      tlc_pkg::CFG_LANE_WIDTH: tilt_cfg.lane_width = v[22:0];
      tlc_pkg::CFG_LANE_DEPTH: tilt_cfg.lane_depth = v[22:0];
      default: ;
    endcase
  endtask

  function automatic int unsigned lanes_on();
    return (tilt_cfg.lane_count > LANES) ? LANES : tilt_cfg.lane_count;
  endfunction

  // rotate about x, add height, find the lane, then queue the count reports
  task automatic tilt_and_count(input tlc_pkg::in_beat_t b);
    longint             px, py, pz, ty, tz, c, s, lo, wd, dp, lf, nr;
    int unsigned        used;
    bit                 reports;
    tlc_pkg::out_beat_t r;
    used    = lanes_on();
    reports = b.frame_end && (used != 0);
    if (b.has_target) begin
      px = longint'($signed(b.pos_x));
      py = longint'($signed(b.pos_y));
      pz = longint'($signed(b.pos_z));
      c  = longint'($signed(tilt_cfg.cos_el));
      s  = longint'($signed(tilt_cfg.sin_el));
      lf = longint'($signed(tilt_cfg.lane_left));
      nr = longint'($signed(tilt_cfg.lane_near));
      wd = longint'(tilt_cfg.lane_width);
      dp = longint'(tilt_cfg.lane_depth);
      ty = clip24((c * py - s * pz) >>> 14);
      tz = clip24(((s * py + c * pz) >>> 14) + longint'($signed(tilt_cfg.height_offset)));
      r = '0;
      r.kind   = tlc_pkg::KIND_TARGET;
      r.out_x  = b.pos_x;
      r.out_y  = ty[23:0];
      r.out_z  = tz[23:0];
      r.out_id = b.target_id;
      for (int l = 0; l < used; l++) begin
        lo = lf + wd * l;
        if (px >= lo && px < lo + wd && ty >= nr && ty < nr + dp) begin
          if (lane_tally[l] != 16'hFFFF) lane_tally[l]++;
          r.lane_hit   = 1'b1;
          r.lane_index = l[2:0];
          r.lane_total = lane_tally[l];
          break;
        end
      end
      r.last = !reports;
      awaited.insert(awaited.size(), r);
    end
    if (b.frame_end) begin
      for (int l = 0; l < used; l++) begin
        r = '0;
        r.kind       = tlc_pkg::KIND_REPORT;
        r.lane_index = l[2:0];
        r.lane_total = lane_tally[l];
        r.last       = (l == used - 1);
        awaited.insert(awaited.size(), r);
      end
      foreach (lane_tally[l]) lane_tally[l] = '0;
    end
  endtask

  task automatic write_reg(input tlc_pkg::cfg_idx_e idx, input int val);
    logic [23:0] v;
    v = 24'(val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    apply_reg(idx, v);
  endtask

  task automatic send_beat(input tlc_pkg::in_beat_t b, input bit typed,
                           input tlc_pkg::out_beat_t want);
    cfg_we_i  <= 1'b0;
    in_data_i <= b;
    push      <= 1'b1;
    do @(posedge clk_i); while (full);
    tilt_and_count(b);
    if (typed) awaited[$] = want;
  endtask

  // frame ends with counting off give no beat, so allow the back end to settle
  task automatic wait_drain();
    push <= 1'b0;
    while (awaited.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  function automatic void add_row(input plan_row_t r);
    plan.insert(plan.size(), r);
  endfunction

  function automatic plan_row_t reg_row(input tlc_pkg::cfg_idx_e idx, input int val);
    plan_row_t r;
    r       = '{kind: ROW_REG, idx: tlc_pkg::CFG_COS_EL, default: '0};
    r.idx   = idx;
    r.wdata = val;
    return r;
  endfunction

  function automatic plan_row_t beat_row(input int x, input int y, input int z, input int id,
                                         input bit has, input bit fe);
    plan_row_t r;
    r                 = '{kind: ROW_BEAT, idx: tlc_pkg::CFG_COS_EL, default: '0};
    r.beat.pos_x      = 24'(x);
    r.beat.pos_y      = 24'(y);
    r.beat.pos_z      = 24'(z);
    r.beat.target_id  = 8'(id);
    r.beat.has_target = has;
    r.beat.frame_end  = fe;
    return r;
  endfunction

  function automatic plan_row_t typed_row(input plan_row_t r, input int x, input int y,
                                          input int z, input int id, input bit hit,
                                          input int idx, input int tot);
    r.typed           = 1'b1;
    r.want            = '0;
    r.want.kind       = tlc_pkg::KIND_TARGET;
    r.want.out_x      = 24'(x);
    r.want.out_y      = 24'(y);
    r.want.out_z      = 24'(z);
    r.want.out_id     = 8'(id);
    r.want.lane_hit   = hit;
    r.want.lane_index = 3'(idx);
    r.want.lane_total = 16'(tot);
    r.want.last       = 1'b1;
    return r;
  endfunction

  task automatic make_target(output tlc_pkg::in_beat_t b);
    longint lf, nr, wd, dp, x, y, z, zr;
    int     sel;
    sel          = $urandom_range(0, 99);
    b.pos_x      = 24'($urandom);
    b.pos_y      = 24'($urandom);
    b.pos_z      = 24'($urandom);
    b.target_id  = 8'($urandom);
    b.has_target = 1'b1;
    b.frame_end  = ($urandom_range(0, 9) == 0);
    if (sel < 75) begin
      lf = longint'($signed(tilt_cfg.lane_left));
      nr = longint'($signed(tilt_cfg.lane_near));
      wd = longint'(tilt_cfg.lane_width);
      dp = longint'(tilt_cfg.lane_depth);
      zr = dp / 16 + 1;
      x  = lf - wd / 4 + longint'($urandom_range(0, 32'(wd * (lanes_on() + 1))));
      y  = nr - dp / 4 + longint'($urandom_range(0, 32'(dp + dp / 2)));
      z  = longint'($urandom_range(0, 32'(2 * zr))) - zr;
      b.pos_x = x[23:0];
      b.pos_y = y[23:0];
      b.pos_z = z[23:0];
    end else if (sel >= 90) begin
      b.has_target = $urandom_range(0, 1);
      b.frame_end  = $urandom_range(0, 1);
    end
  endtask

  task automatic shuffle_setup(input bit wide);
    int n, w, d;
    n = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(0, 15);
    w = $urandom_range(16, 4096);
    d = $urandom_range(16, 8192);
    if (wide) begin
      write_reg(tlc_pkg::CFG_COS_EL, $urandom_range(0, 32768) - 16384);
      write_reg(tlc_pkg::CFG_SIN_EL, $urandom_range(0, 32768) - 16384);
      write_reg(tlc_pkg::CFG_HEIGHT, $urandom);
    end else begin
      write_reg(tlc_pkg::CFG_COS_EL, $urandom_range(14000, 16384));
      write_reg(tlc_pkg::CFG_SIN_EL, $urandom_range(0, 12000) - 6000);
      write_reg(tlc_pkg::CFG_HEIGHT, $urandom_range(0, 8192) - 4096);
    end
    write_reg(tlc_pkg::CFG_LANE_COUNT, n);
    write_reg(tlc_pkg::CFG_LANE_LEFT, $urandom_range(0, 2048) - 1024 - (n * w) / 2);
    write_reg(tlc_pkg::CFG_LANE_NEAR, -$urandom_range(0, d));
    write_reg(tlc_pkg::CFG_LANE_WIDTH, w);
    write_reg(tlc_pkg::CFG_LANE_DEPTH, d);
  endtask

  task automatic run_phase(input int tx_pct, input int rx_pct, input bit wide,
                           input bit with_hold, input bit with_pause);
    tlc_pkg::in_beat_t  b;
    tlc_pkg::out_beat_t none;
    none = '0;
    wait_drain();
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    shuffle_setup(wide);
    if (with_hold) hold_req = 1'b1;
    for (int i = 0; i < 25; i++) begin
      if (with_pause && i == 12) wait_drain();
      make_target(b);
      send_beat(b, 1'b0, none);
      if ($urandom_range(0, 99) < tx_idle_pct) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end
    end
  endtask

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < RUN_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int hold_left;
    hold_left = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  task automatic check_field(input string name, input logic [23:0] want,
                             input logic [23:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk_i) begin
    tlc_pkg::out_beat_t w;
    if (rst_ni && pop && !empty) begin
      if (awaited.size() == 0) begin
        $error("result beat with nothing awaited: %h", out_data_o);
        failures++;
      end else begin
        w = awaited.pop_front();
        check_field("kind", w.kind, out_data_o.kind);
        check_field("out_x", w.out_x, out_data_o.out_x);
        check_field("out_y", w.out_y, out_data_o.out_y);
        check_field("out_z", w.out_z, out_data_o.out_z);
        check_field("out_id", w.out_id, out_data_o.out_id);
        check_field("lane_hit", w.lane_hit, out_data_o.lane_hit);
        check_field("lane_index", w.lane_index, out_data_o.lane_index);
        check_field("lane_total", w.lane_total, out_data_o.lane_total);
        check_field("last", w.last, out_data_o.last);
      end
    end
  end

  initial begin
    failures     = 0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_req     = 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= '0;
    cfg_wdata_i  <= '0;
    push         <= 1'b0;
    in_data_i    <= '0;

    tilt_cfg        = '0;
    tilt_cfg.cos_el = 16'sd16384;
    foreach (lane_tally[l]) lane_tally[l] = '0;

    // after reset: unity tilt, no lanes
    add_row(typed_row(beat_row('h7FFFFF, 'h7FFFFF, -8388608, 'hFF, 1, 0),
                      'h7FFFFF, 'h7FFFFF, -8388608, 'hFF, 0, 0, 0));
    add_row(typed_row(beat_row(-8388608, -8388608, 'h7FFFFF, 0, 1, 0),
                      -8388608, -8388608, 'h7FFFFF, 0, 0, 0, 0));
    add_row(beat_row('h555555, 'hAAAAAA, 'h333333, 'hC3, 0, 0));
    add_row(beat_row(0, 0, 0, 0, 0, 1));
    add_row(typed_row(beat_row('h123456, 1, -1, 'h5A, 1, 1),
                      'h123456, 1, -1, 'h5A, 0, 0, 0));
    // floor on a negative product
    add_row(reg_row(tlc_pkg::CFG_COS_EL, 16383));
    add_row(typed_row(beat_row(0, -1, 0, 1, 1, 0), 0, -1, 0, 1, 0, 0, 0));
    // saturation of the rotated y
    add_row(reg_row(tlc_pkg::CFG_COS_EL, 16384));
    add_row(reg_row(tlc_pkg::CFG_SIN_EL, 16384));
    add_row(typed_row(beat_row(0, 'h7FFFFF, -8388608, 2, 1, 0),
                      0, 'h7FFFFF, -1, 2, 0, 0, 0));
    add_row(reg_row(tlc_pkg::CFG_COS_EL, -16384));
    add_row(reg_row(tlc_pkg::CFG_SIN_EL, -16384));
    add_row(reg_row(tlc_pkg::CFG_HEIGHT, 'h7FFFFF));
    add_row(typed_row(beat_row(5, -8388608, -8388608, 3, 1, 0),
                      5, 0, 'h7FFFFF, 3, 0, 0, 0));
    add_row(reg_row(tlc_pkg::CFG_COS_EL, 0));
    add_row(reg_row(tlc_pkg::CFG_SIN_EL, 16384));
    add_row(reg_row(tlc_pkg::CFG_HEIGHT, -8388608));
    add_row(beat_row('h0F0F0F, 1234, -5678, 4, 1, 0));
    // three small lanes
    add_row(reg_row(tlc_pkg::CFG_COS_EL, 16384));
    add_row(reg_row(tlc_pkg::CFG_SIN_EL, 0));
    add_row(reg_row(tlc_pkg::CFG_HEIGHT, 0));
    add_row(reg_row(tlc_pkg::CFG_LANE_COUNT, 3));
    add_row(reg_row(tlc_pkg::CFG_LANE_LEFT, 0));
    add_row(reg_row(tlc_pkg::CFG_LANE_NEAR, 0));
    add_row(reg_row(tlc_pkg::CFG_LANE_WIDTH, 256));
    add_row(reg_row(tlc_pkg::CFG_LANE_DEPTH, 256));
    add_row(typed_row(beat_row(0, 0, 77, 10, 1, 0), 0, 0, 77, 10, 1, 0, 1));
    add_row(typed_row(beat_row(767, 255, 0, 11, 1, 0), 767, 255, 0, 11, 1, 2, 1));
    add_row(beat_row(768, 0, 0, 12, 1, 0));
    add_row(beat_row(0, 256, 0, 13, 1, 0));
    add_row(beat_row(-1, 0, 0, 14, 1, 0));
    add_row(beat_row(300, 10, 0, 15, 1, 1));
    // too many lanes, zero depth
    add_row(reg_row(tlc_pkg::CFG_LANE_COUNT, 15));
    add_row(reg_row(tlc_pkg::CFG_LANE_WIDTH, 'h7FFFFF));
    add_row(reg_row(tlc_pkg::CFG_LANE_DEPTH, 0));
    add_row(beat_row(0, 0, 0, 16, 1, 0));
    add_row(beat_row(0, 0, 0, 0, 0, 1));
    // widest lanes from the far corner
    add_row(reg_row(tlc_pkg::CFG_LANE_DEPTH, 'h7FFFFF));
    add_row(reg_row(tlc_pkg::CFG_LANE_LEFT, -8388608));
    add_row(reg_row(tlc_pkg::CFG_LANE_NEAR, -8388608));
    add_row(beat_row(-8388608, -8388608, 0, 18, 1, 0));
    add_row(beat_row('h7FFFFF, 'h7FFFFF, 0, 19, 1, 0));
    add_row(beat_row(100, -5, 0, 20, 1, 1));
    // zero width
    add_row(reg_row(tlc_pkg::CFG_LANE_COUNT, 8));
    add_row(reg_row(tlc_pkg::CFG_LANE_WIDTH, 0));
    add_row(beat_row(0, 0, 0, 21, 1, 1));

    wait (rst_ni === 1'b1);
    repeat (4) @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        if (i > 0 && plan[i-1].kind == ROW_BEAT) wait_drain();
        write_reg(plan[i].idx, plan[i].wdata);
      end else begin
        send_beat(plan[i].beat, plan[i].typed, plan[i].want);
      end
    end

    run_phase(0, 0, 1'b0, 1'b1, 1'b0);
    run_phase(46, 0, 1'b1, 1'b0, 1'b1);
    run_phase(0, 46, 1'b0, 1'b0, 1'b0);
    run_phase(27, 27, 1'b1, 1'b0, 1'b0);

    wait_drain();
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
